@@ src/side_pkg.sv @@
// Shared types, constants and helpers for the sparse index delta encoder.
package side_pkg;

  localparam int unsigned IndexBitsDef = 32;
  localparam int unsigned CfgW         = 16;
  localparam int unsigned DeltaW       = 64;
  localparam int unsigned NbitsW       = 7;
  localparam int unsigned InDataW      = 64;
  localparam int unsigned OutDataW     = 136;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_SCAN,
    ST_EMIT
  } side_state_e;

  // bit-length scanner status
  typedef struct packed {
    logic              done;
    logic [NbitsW-1:0] bits;
  } side_len_t;

  // highest set bit position plus one of a byte, 0 for zero
  function automatic logic [3:0] byte_len(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        n = 4'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

@@ src/sparse_index_delta_encoder_unit.sv @@
// Sparse index delta encoder: top level with control, serial multiply and output register.
//
// Usage: one nonzero entry per request on the s_axis channel (row, column and a
// start-of-matrix flag in tuser); one result per request on the m_axis channel
// (delta, its bit length, running bit total, and a group-start flag in tuser).
// group_rows is written through cfg_we_i / cfg_wdata_i; the user must write it only
// while the block is idle, the block itself does not enforce it. 0 or 1 gives plain per-row
// column deltas, larger values group rows. Timing: an entry is taken only in the idle
// state. The row / group_rows divide runs one quotient bit per cycle, and the
// group_rows * column-difference product is built by shift-and-add while it runs.
// The delta's bit length is then found one byte per cycle. The result shows on
// m_axis, and s_axis_tready rises in the same cycle, so the block takes a new
// request only once it is through with the previous one.
// The output register lets a new request in while the previous result waits;
// if the receiver still stalls when the next result is ready, the block holds it
// and keeps s_axis_tready low.
// Reset clears the previous position, the group state, the bit total and
// group_rows; m_axis_tvalid is low after reset.
module sparse_index_delta_encoder_unit #(
  parameter int unsigned INDEX_BITS = side_pkg::IndexBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [side_pkg::CfgW-1:0]     cfg_wdata_i,    // group_rows
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] row_index, [63:32] col_index
  input  logic [side_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                          s_axis_tuser,   // [0] start_matrix
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [63:0] delta_value, [70:64] delta_bits, [134:71] total_bits, [135] zero
  output logic [side_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tuser    // [0] group_start
);

  localparam int unsigned IB   = INDEX_BITS;
  localparam int unsigned Iter = (IB > side_pkg::CfgW) ? IB : side_pkg::CfgW;
  localparam int unsigned DW   = side_pkg::DeltaW;

  side_pkg::side_state_e state_q, state_d;

  logic accept, eval, emit, out_free;

  // configuration
  logic [side_pkg::CfgW-1:0] group_rows_q;

  // request being worked on
  logic [IB-1:0]             row_q, col_q;
  logic                      start_q;
  logic [DW-1:0]             acc_q;      // row - last_row - 1, plus product
  logic [DW-1:0]             mcand_q;    // col - last_col, shifted left per step
  logic [side_pkg::CfgW-1:0] mplier_q;
  logic [DW-1:0]             colm1_q;    // col - last_col - 1

  // encoder state
  logic [IB-1:0] last_row_q, last_col_q, last_group_q;
  logic          have_last_q;
  logic [DW-1:0] bit_total_q, base_q;
  logic [DW-1:0] delta_q;
  logic          first_q;

  // output register
  logic                          m_valid_q;
  logic [side_pkg::OutDataW-1:0] m_data_q;
  logic                          m_user_q;

  logic [IB-1:0] row_m, col_m;
  assign row_m = s_axis_tdata[IB-1:0];
  assign col_m = s_axis_tdata[32 +: IB];

  // divider and bit-length scanner
  logic                div_done;
  logic [Iter-1:0]     quot;
  side_pkg::side_len_t len_st;

  side_serial_div #(
    .DW (Iter),
    .VW (side_pkg::CfgW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (Iter'(row_m)),
    .divisor_i  (group_rows_q),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // entry encode, done in the cycle the quotient lands
  logic          grouped, first;
  logic [IB-1:0] grp;
  logic [DW-1:0] delta;

  assign grouped = group_rows_q > side_pkg::CfgW'(1);
  assign grp     = grouped ? quot[IB-1:0] : row_q;
  assign first   = start_q || !have_last_q || (grp != last_group_q);
  assign delta   = first ? DW'(col_q) : (grouped ? acc_q : colm1_q);

  side_bitlen u_len (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (eval),
    .value_i  (delta),
    .status_o (len_st)
  );

  // sequencer
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    accept  = 1'b0;
    eval    = 1'b0;
    emit    = 1'b0;
    case (state_q)
      side_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          accept  = 1'b1;
          state_d = side_pkg::ST_CALC;
        end
      end
      side_pkg::ST_CALC: begin
        if (div_done) begin
          eval    = 1'b1;
          state_d = side_pkg::ST_SCAN;
        end
      end
      side_pkg::ST_SCAN: begin
        if (len_st.done) begin
          state_d = side_pkg::ST_EMIT;
        end
      end
      side_pkg::ST_EMIT: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = side_pkg::ST_IDLE;
        end
      end
      default: state_d = side_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= side_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control state
  logic [DW-1:0] total_d;
  assign total_d = base_q + DW'(len_st.bits);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_rows_q <= '0;
      last_row_q   <= '0;
      last_col_q   <= '0;
      last_group_q <= '0;
      have_last_q  <= 1'b0;
      bit_total_q  <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        group_rows_q <= cfg_wdata_i;
      end
      if (eval) begin
        last_row_q   <= row_q;
        last_col_q   <= col_q;
        last_group_q <= grp;
        have_last_q  <= 1'b1;
      end
      if (emit) begin
        bit_total_q <= total_d;
        m_valid_q   <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q    <= row_m;
      col_q    <= col_m;
      start_q  <= s_axis_tuser;
      acc_q    <= DW'(row_m) + ~DW'(last_row_q);
      mcand_q  <= DW'(col_m) - DW'(last_col_q);
      colm1_q  <= DW'(col_m) + ~DW'(last_col_q);
      mplier_q <= group_rows_q;
    end else if (state_q == side_pkg::ST_CALC) begin
      // shift-and-add multiply, one multiplier bit per cycle
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end
    if (eval) begin
      delta_q <= delta;
      first_q <= first;
      base_q  <= start_q ? '0 : bit_total_q;
    end
    if (emit) begin
      m_data_q <= {1'b0, total_d, len_st.bits, delta_q};
      m_user_q <= first_q;
    end
  end

  assign s_axis_tready = (state_q == side_pkg::ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

@@ src/side_serial_div.sv @@
// Restoring divider, one quotient bit per cycle.
module side_serial_div #(
  parameter int unsigned DW = 32,
  parameter int unsigned VW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DW);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [VW-1:0] rem_q, dvs_q;
  logic [DW-1:0] sh_q;   // dividend out at the top, quotient in at the bottom

  logic [VW:0]   trial;
  logic [VW+1:0] diff;
  logic          ge;

  assign trial = {rem_q, sh_q[DW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};
  assign ge    = ~diff[VW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CW'(1);
      if (cnt_q == CW'(DW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      sh_q  <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
      sh_q  <= {sh_q[DW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = sh_q;

endmodule

@@ src/side_bitlen.sv @@
// Significant bit length of a 64-bit word, scanned one byte per cycle from the top.
module side_bitlen (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [side_pkg::DeltaW-1:0] value_i,
  output side_pkg::side_len_t         status_o
);

  logic                        busy_q, done_q;
  logic [2:0]                  idx_q;
  logic [side_pkg::DeltaW-1:0] scan_q;
  logic [side_pkg::NbitsW-1:0] bits_q;
  logic [7:0]                  top;
  logic                        hit;

  assign top = scan_q[side_pkg::DeltaW-1 -: 8];
  assign hit = (top != 8'd0) || (idx_q == 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
      bits_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      idx_q  <= 3'd7;
    end else if (busy_q) begin
      if (hit) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
        bits_q <= side_pkg::NbitsW'({idx_q, 3'b000}) +
                  side_pkg::NbitsW'(side_pkg::byte_len(top));
      end else begin
        idx_q <= idx_q - 3'd1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      scan_q <= value_i;
    end else if (busy_q) begin
      scan_q <= scan_q << 8;
    end
  end

  assign status_o.done = done_q;
  assign status_o.bits = bits_q;

endmodule

@@ src/side_checker.sv @@
// Port-level checks for the sparse index delta encoder, bound to the top level.
module side_port_checks (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [side_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tuser
);

  // one request at a time: ready drops after a request is taken
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while previous one in flight");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed under stall");

  // bit length never exceeds the word width
  a_bits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[70:64] <= 7'd64)
    else $error("delta_bits out of range");

  // zero delta exactly when zero bit length
  a_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[63:0] == 64'd0) == (m_axis_tdata[70:64] == 7'd0)))
    else $error("delta_bits disagrees with delta_value");

endmodule

bind sparse_index_delta_encoder_unit side_port_checks u_side_port_checks (.*);

@@ bench/side_checker.sv @@
`timescale 1ns / 100ps
// Checker for the sparse index delta encoder: predicts each result and compares it.
module side_checker #(
  parameter int unsigned IndexBits = side_pkg::IndexBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [side_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [side_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                          s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [side_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          m_axis_tuser,
  output int unsigned                   outstanding_o,
  output int unsigned                   fail_count_o
);

  localparam logic [31:0] IdxMask = 32'((64'd1 << IndexBits) - 64'd1);

  typedef struct packed {
    logic [side_pkg::DeltaW-1:0] delta;
    logic [side_pkg::NbitsW-1:0] nbits;
    logic                        grp_start;
    logic [63:0]                 total;
  } enc_result_t;

  // encoder state as the block should hold it
  logic [side_pkg::CfgW-1:0] group_rows_q;
  logic [31:0]               last_row_q;
  logic [31:0]               last_col_q;
  logic [31:0]               last_group_q;
  logic                      have_last_q;
  logic [63:0]               bit_total_q;

  enc_result_t  expected_codes[$];
  enc_result_t  exp_r;
  enc_result_t  act_r;
  int unsigned  mismatches;

  function automatic enc_result_t encode_entry(input logic [31:0] row_in,
                                               input logic [31:0] col_in,
                                               input logic        start);
    logic [31:0] row;
    logic [31:0] col;
    logic [31:0] grp;
    logic        grouped;
    logic [63:0] delta;
    logic [6:0]  nb;
    enc_result_t r;
    row     = row_in & IdxMask;
    col     = col_in & IdxMask;
    grouped = group_rows_q > 1;
    grp     = grouped ? row / {16'b0, group_rows_q} : row;
    if (start) begin
      have_last_q  = 1'b0;
      last_row_q   = '0;
      last_col_q   = '0;
      last_group_q = '0;
      bit_total_q  = '0;
    end
    r.grp_start = !have_last_q || (grp != last_group_q);
    if (r.grp_start) begin
      delta = {32'b0, col};
    end else if (grouped) begin
      delta = {32'b0, row} - {32'b0, last_row_q} - 64'd1
            + {48'b0, group_rows_q} * ({32'b0, col} - {32'b0, last_col_q});
    end else begin
      delta = {32'b0, col} - {32'b0, last_col_q} - 64'd1;
    end
    nb = '0;
    for (int i = 0; i < 64; i++) begin
      if (delta[i]) begin
        nb = 7'(i + 1);
      end
    end
    bit_total_q  = bit_total_q + {57'b0, nb};
    last_row_q   = row;
    last_col_q   = col;
    last_group_q = grp;
    have_last_q  = 1'b1;
    r.delta      = delta;
    r.nbits      = nb;
    r.total      = bit_total_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_rows_q  = '0;
      last_row_q    = '0;
      last_col_q    = '0;
      last_group_q  = '0;
      have_last_q   = 1'b0;
      bit_total_q   = '0;
      mismatches    = 0;
      expected_codes.delete();
      outstanding_o <= 0;
      fail_count_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        group_rows_q = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_codes.push_back(encode_entry(s_axis_tdata[31:0], s_axis_tdata[63:32],
                                              s_axis_tuser));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        act_r.delta     = m_axis_tdata[63:0];
        act_r.nbits     = m_axis_tdata[70:64];
        act_r.total     = m_axis_tdata[134:71];
        act_r.grp_start = m_axis_tuser;
        if (expected_codes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with nothing expected: delta %h bits %0d start %0b total %h",
                     $realtime, act_r.delta, act_r.nbits, act_r.grp_start, act_r.total);
          end
        end else begin
          exp_r = expected_codes.pop_front();
          if (act_r.delta != exp_r.delta || act_r.nbits != exp_r.nbits ||
              act_r.grp_start != exp_r.grp_start || act_r.total != exp_r.total) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch: delta %h/%h bits %0d/%0d start %0b/%0b total %h/%h",
                       $realtime, exp_r.delta, act_r.delta, exp_r.nbits, act_r.nbits,
                       exp_r.grp_start, act_r.grp_start, exp_r.total, act_r.total);
            end
          end
        end
      end
      outstanding_o <= expected_codes.size();
      fail_count_o  <= mismatches;
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the sparse index delta encoder: stimulus, stalls and verdict.
module tb;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [side_pkg::CfgW-1:0]     cfg_wdata_i;    // group_rows
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  // [31:0] row_index, [63:32] col_index
  logic [side_pkg::InDataW-1:0]  s_axis_tdata;
  logic                          s_axis_tuser;   // [0] start_matrix
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  // [63:0] delta_value, [70:64] delta_bits, [134:71] total_bits, [135] zero
  logic [side_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          m_axis_tuser;   // [0] group_start

  int unsigned outstanding;   // requests accepted but not yet answered
  int unsigned fail_count;
  int unsigned burst_left;    // requests left in the current sender burst

  sparse_index_delta_encoder_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  side_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .outstanding_o(outstanding),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one entry and hold it until the block takes it. Inside a burst the
  // next request follows with tvalid left high; a burst ends in a random gap.
  task automatic send_entry(input logic [31:0] row, input logic [31:0] col,
                            input logic start);
    s_axis_tdata  <= {col, row};
    s_axis_tuser  <= start;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      // short gaps mostly, now and then one longer than a whole calculation
      if ($urandom_range(0, 1) == 0) begin
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 60)) @(posedge clk_i);
      end
      // some bursts are long enough to give stretches with no sender idling
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                               : $urandom_range(0, 5);
    end
  endtask

  // Stop offering and wait until every result has come back. The count from
  // the checker is registered, so look only from the next edge on.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // group_rows may only change while the block is idle, so drain first
  task automatic set_group_rows(input logic [side_pkg::CfgW-1:0] value);
    drain();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // One phase of random traffic: mostly well-formed matrices (rows rising,
  // columns rising within a row), with some noise and some broken order.
  task automatic run_phase(input int unsigned n_items, input int unsigned row_step);
    logic [31:0] cur_row;
    logic [31:0] cur_col;
    logic [31:0] row;
    logic [31:0] col;
    logic        start;
    int unsigned roll;
    cur_row = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1000) : $urandom;
    cur_col = $urandom_range(0, 50);
    for (int unsigned k = 0; k < n_items; k++) begin
      roll  = $urandom_range(0, 99);
      start = 1'b0;
      if (k == 0) begin
        start = ($urandom_range(0, 3) != 0);
        row   = cur_row;
        col   = cur_col;
      end else if (roll < 6) begin
        // noise: anywhere in the index space
        row   = $urandom;
        col   = $urandom;
        start = ($urandom_range(0, 15) == 0);
      end else if (roll < 10) begin
        // broken order: step back in row or column
        cur_row = cur_row - $urandom_range(0, 3);
        cur_col = cur_col - $urandom_range(1, 20);
        row     = cur_row;
        col     = cur_col;
      end else if (roll < 12) begin
        // a fresh matrix, sometimes high in the index space
        start   = 1'b1;
        cur_row = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 500) : $urandom;
        cur_col = $urandom_range(0, 30);
        row     = cur_row;
        col     = cur_col;
      end else begin
        if ($urandom_range(0, 9) < 3) begin
          cur_row = cur_row + $urandom_range(1, row_step);
          cur_col = $urandom_range(0, 20);
        end else if ($urandom_range(0, 39) == 0) begin
          cur_col = cur_col + $urandom;   // big jump, reaches the high bits
        end else begin
          cur_col = cur_col + $urandom_range(1, 8);
        end
        row = cur_row;
        col = cur_col;
      end
      send_entry(row, col, start);
    end
  endtask

  // Main stimulus: directed cases first, then random phases under changing
  // group_rows settings.
  initial begin
    logic [side_pkg::CfgW-1:0] gr;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    burst_left    = 0;
    rst_ni        <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni        <= 1'b1;
    @(posedge clk_i);

    // Row mode from the reset value of group_rows
    send_entry(32'd5, 32'd7, 1'b0);            // first entry after reset
    send_entry(32'd5, 32'd10, 1'b0);           // next column in the same row
    send_entry(32'd5, 32'd10, 1'b0);           // repeated column: delta wraps to all ones
    send_entry(32'd5, 32'd3, 1'b0);            // column goes backwards
    send_entry(32'd6, 32'd0, 1'b0);            // new row, zero delta
    send_entry(32'd6, 32'hFFFF_FFFF, 1'b0);    // widest column step
    send_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_entry(32'hFFFF_FFFF, 32'd0, 1'b1);    // matrix start inside a row
    send_entry(32'd0, 32'd0, 1'b0);            // row goes backwards

    // Widest groups
    set_group_rows(16'hFFFF);
    send_entry(32'd0, 32'd5, 1'b1);
    send_entry(32'd1, 32'd2, 1'b0);            // same group, column back: product wraps
    send_entry(32'd65534, 32'hFFFF_FFFF, 1'b0);
    send_entry(32'd65535, 32'd1, 1'b0);        // next group
    send_entry(32'hFFFF_FFFF, 32'd0, 1'b0);
    send_entry(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0);

    // Register change without a matrix start: old last_group is compared as is
    set_group_rows(16'd1);
    send_entry(32'd3, 32'd4, 1'b0);
    send_entry(32'd3, 32'd9, 1'b0);

    // Small groups
    set_group_rows(16'd3);
    send_entry(32'd0, 32'd1, 1'b1);
    send_entry(32'd2, 32'd5, 1'b0);
    send_entry(32'd1, 32'd5, 1'b0);            // row back within the group
    send_entry(32'd3, 32'd0, 1'b0);            // next group
    send_entry(32'd5, 32'd0, 1'b0);            // same column, later row

    // Random phases, each under its own setting, the extremes among them
    for (int unsigned ph = 0; ph < 18; ph++) begin
      case (ph % 8)
        0:       gr = 16'd0;
        1:       gr = 16'd1;
        2:       gr = 16'hFFFF;
        3:       gr = 16'($urandom_range(2, 8));
        4:       gr = 16'($urandom);
        5:       gr = 16'($urandom_range(2, 64));
        6:       gr = 16'd2;
        default: gr = 16'($urandom_range(9, 4096));
      endcase
      set_group_rows(gr);
      run_phase(105, (gr > 1 && $urandom_range(0, 1) == 0) ? gr : 3);
    end

    drain();
    // room for a stray late result to show up
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Receiver: stall patterns of its own, in segments of random length. Twice
  // it holds off for a long stretch while the sender keeps offering, so the
  // output register fills and the block has to stall its input.
  initial begin
    int unsigned mode;
    int unsigned seg;
    int unsigned cycles;
    cycles = 0;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(20, 300);
      repeat (seg) begin
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
          default: m_axis_tready <= ((cycles % 7) < 3);
        endcase
        @(posedge clk_i);
        cycles++;
        if (cycles == 8000 || cycles == 50000) begin
          m_axis_tready <= 1'b0;
          repeat (700) @(posedge clk_i);
          cycles += 700;
        end
      end
    end
  end

  // Watchdog, far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("tb failed");
    $finish;
  end

endmodule

@@ sparse_index_delta_encoder_unit.f @@
src/side_pkg.sv
src/side_serial_div.sv
src/side_bitlen.sv
src/sparse_index_delta_encoder_unit.sv
src/side_checker.sv
bench/side_checker.sv
bench/tb.sv
